@@ hdl/fre_pkg.sv @@
// shared types and constants of the fragment reassembly engine
package fre_pkg;

	localparam int ADDR_W      = 17;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SUB    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_IR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SCRIPT = 2'd2;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_UNENC    = 3'd1;
	localparam logic [2:0] ST_BADTYPE  = 3'd2;
	localparam logic [2:0] ST_RUN      = 3'd3;
	localparam logic [2:0] ST_COMPLETE = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;

	typedef struct packed {
		logic [2:0]        kind;
		logic [31:0]       tag;
		logic [7:0]        ptype;
		logic [7:0]        index;
		logic [7:0]        total;
		logic [7:0]        data;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic              wr_ok;
		logic              mark_ok;
		logic              rd_ok;
	} entry_t;

endpackage

@@ hdl/fragment_reassembly_engine_unit.sv @@
// top level of the fragment reassembly engine
//
//  channel  handshake              contents
//  in       in_valid / in_ready    mode, tag, type, index, total, flags, byte, read address
//  out      out_valid / out_ready  status, payload type, length, count, read byte
//  cfg      cfg_wr_en              cfg_index, cfg_data (type code registers)
//
// one transaction per cycle sustained while out_ready holds; an accepted transaction is registered in a queue slot
// and then in the result register before it is offered; the buffer read shares the result register stage
// reset clears assembly state and the seen bitmap at once; buffer contents are not cleared
// the two-entry queue absorbs output stalls, in_ready drops only when it is full
module fragment_reassembly_engine_unit #(
	parameter int CHUNK_BYTES   = 32,
	parameter int BUFFER_BYTES  = 4096,
	parameter int MAX_FRAGMENTS = 129
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [31:0]                   name_tag,
	input  logic [7:0]                    payload_type,
	input  logic [7:0]                    frag_index,
	input  logic [7:0]                    frag_total,
	input  logic                          encrypted,
	input  logic [4:0]                    byte_pos,
	input  logic [7:0]                    data_byte,
	input  logic                          byte_valid,
	input  logic                          last_beat,
	input  logic [11:0]                   read_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [7:0]                    out_payload_type,
	output logic [12:0]                   file_length,
	output logic [7:0]                    frags_seen,
	output logic [7:0]                    read_byte
);

	fre_pkg::entry_t front_entry;
	fre_pkg::entry_t head;
	logic not_full;
	logic not_empty;
	logic pop;
	logic push;

	assign in_ready = not_full;
	assign push     = in_valid && not_full;

	fre_front #(
		.CHUNK_BYTES   (CHUNK_BYTES),
		.BUFFER_BYTES  (BUFFER_BYTES),
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.name_tag     (name_tag),
		.payload_type (payload_type),
		.frag_index   (frag_index),
		.frag_total   (frag_total),
		.encrypted    (encrypted),
		.byte_pos     (byte_pos),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last_beat    (last_beat),
		.read_address (read_address),
		.entry        (front_entry)
	);

	fre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.not_full   (not_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	fre_back #(
		.BUFFER_BYTES  (BUFFER_BYTES),
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.not_empty        (not_empty),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.out_payload_type (out_payload_type),
		.file_length      (file_length),
		.frags_seen       (frags_seen),
		.read_byte        (read_byte)
	);

endmodule

@@ hdl/fre_front.sv @@
// front end: type code registers and classification of incoming transactions
module fre_front #(
	parameter int CHUNK_BYTES   = 32,
	parameter int BUFFER_BYTES  = 4096,
	parameter int MAX_FRAGMENTS = 129
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [fre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           mode,
	input  logic [31:0]                    name_tag,
	input  logic [7:0]                     payload_type,
	input  logic [7:0]                     frag_index,
	input  logic [7:0]                     frag_total,
	input  logic                           encrypted,
	input  logic [4:0]                     byte_pos,
	input  logic [7:0]                     data_byte,
	input  logic                           byte_valid,
	input  logic                           last_beat,
	input  logic [11:0]                    read_address,
	output fre_pkg::entry_t                entry
);

	logic [7:0] type_sub_q;
	logic [7:0] type_ir_q;
	logic [7:0] type_script_q;
	logic [fre_pkg::ADDR_W-1:0] wr_addr;
	logic [fre_pkg::ADDR_W-1:0] rd_addr;
	logic type_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_sub_q    <= 8'd0;
			type_ir_q     <= 8'd1;
			type_script_q <= 8'd2;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fre_pkg::CFG_TYPE_SUB:    type_sub_q    <= cfg_data;
				fre_pkg::CFG_TYPE_IR:     type_ir_q     <= cfg_data;
				fre_pkg::CFG_TYPE_SCRIPT: type_script_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign type_ok = (payload_type == type_sub_q) || (payload_type == type_ir_q) ||
		(payload_type == type_script_q);
	assign wr_addr = fre_pkg::ADDR_W'(frag_index) * fre_pkg::ADDR_W'(CHUNK_BYTES) +
		fre_pkg::ADDR_W'(byte_pos);
	assign rd_addr = fre_pkg::ADDR_W'(read_address);

	always_comb begin
		entry         = '0;
		entry.tag     = name_tag;
		entry.ptype   = payload_type;
		entry.index   = frag_index;
		entry.total   = frag_total;
		entry.data    = data_byte;
		entry.last    = last_beat;
		entry.addr    = wr_addr;
		entry.mark_ok = fre_pkg::ADDR_W'(frag_index) < fre_pkg::ADDR_W'(MAX_FRAGMENTS);
		entry.wr_ok   = byte_valid && entry.mark_ok &&
			(fre_pkg::ADDR_W'(byte_pos) < fre_pkg::ADDR_W'(CHUNK_BYTES)) &&
			(wr_addr < fre_pkg::ADDR_W'(BUFFER_BYTES));
		entry.rd_ok   = 1'b0;
		if (mode) begin
			entry.kind  = fre_pkg::ST_READ;
			entry.ptype = 8'd0;
			entry.addr  = rd_addr;
			entry.wr_ok = 1'b0;
			entry.rd_ok = rd_addr < fre_pkg::ADDR_W'(BUFFER_BYTES);
		end else if (!encrypted) begin
			entry.kind  = fre_pkg::ST_UNENC;
		end else if (!type_ok) begin
			entry.kind  = fre_pkg::ST_BADTYPE;
		end else if (!byte_valid && frag_total <= 8'd1) begin
			entry.kind  = fre_pkg::ST_RUN;
		end else begin
			entry.kind  = fre_pkg::ST_STORED;
		end
	end

endmodule

@@ hdl/fre_queue.sv @@
// short queue of classified transactions between front and back end
module fre_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fre_pkg::entry_t push_entry,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output fre_pkg::entry_t head
);

	localparam int PW = $clog2(fre_pkg::QUEUE_DEPTH);

	fre_pkg::entry_t slots_q [fre_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign not_full  = count_q != (PW+1)'(fre_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(fre_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(fre_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/fre_back.sv @@
// back end: assembly state, seen bitmap, file buffer and result register
module fre_back #(
	parameter int BUFFER_BYTES  = 4096,
	parameter int MAX_FRAGMENTS = 129
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  fre_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [7:0]      out_payload_type,
	output logic [12:0]     file_length,
	output logic [7:0]      frags_seen,
	output logic [7:0]      read_byte
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int IW = $clog2(MAX_FRAGMENTS);

	logic [7:0] file_buffer [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	logic [MAX_FRAGMENTS-1:0] seen_map_q;
	logic [7:0]  seen_count_q;
	logic [7:0]  expected_total_q;
	logic [31:0] current_tag_q;
	logic [LW-1:0] length_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  ptype_q;
	logic [LW-1:0] len_out_q;
	logic [7:0]  cnt_out_q;
	logic        rd_ok_q;

	logic is_data;
	logic clr;
	logic [LW-1:0] base_len;
	logic [7:0]  base_cnt;
	logic [IW-1:0] seen_idx;
	logic seen_bit;
	logic marked;
	logic [MAX_FRAGMENTS-1:0] seen_base;
	logic [MAX_FRAGMENTS-1:0] seen_set;
	logic [fre_pkg::ADDR_W-1:0] addr_next;
	logic [LW-1:0] new_len;
	logic [7:0]  new_cnt;
	logic complete;
	logic mem_we;
	logic mem_re;

	assign pop     = not_empty && (!out_valid_q || out_ready);
	assign is_data = head.kind == fre_pkg::ST_STORED;
	assign clr     = (head.tag != current_tag_q) || (head.total != expected_total_q);
	assign base_len = clr ? '0 : length_q;
	assign base_cnt = clr ? 8'd0 : seen_count_q;
	assign seen_idx = head.index[IW-1:0];
	assign seen_bit = seen_map_q[seen_idx] && !clr;
	assign marked   = head.last && head.mark_ok && !seen_bit;
	assign seen_base = clr ? '0 : seen_map_q;
	assign seen_set  = marked ? ({{(MAX_FRAGMENTS-1){1'b0}}, 1'b1} << seen_idx) : '0;
	assign addr_next = head.addr + 1'b1;
	assign new_len  = (head.wr_ok && (addr_next > fre_pkg::ADDR_W'(base_len))) ?
		LW'(addr_next) : base_len;
	assign new_cnt  = base_cnt + {7'd0, marked};
	assign complete = head.last && (new_cnt >= head.total);
	assign mem_we   = pop && is_data && head.wr_ok;
	assign mem_re   = pop && head.kind == fre_pkg::ST_READ;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			file_buffer[head.addr[AW-1:0]] <= head.data;
		end
		if (mem_re) begin
			rd_data_q <= file_buffer[head.addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_map_q       <= '0;
			seen_count_q     <= 8'd0;
			expected_total_q <= 8'd0;
			current_tag_q    <= 32'd0;
			length_q         <= '0;
		end else if (pop && is_data) begin
			if (complete) begin
				seen_map_q       <= '0;
				seen_count_q     <= 8'd0;
				expected_total_q <= 8'd0;
				current_tag_q    <= 32'd0;
				length_q         <= '0;
			end else begin
				seen_map_q       <= seen_base | seen_set;
				seen_count_q     <= new_cnt;
				expected_total_q <= head.total;
				current_tag_q    <= head.tag;
				length_q         <= new_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ptype_q <= head.ptype;
			rd_ok_q <= mem_re && head.rd_ok;
			if (is_data) begin
				status_q  <= complete ? fre_pkg::ST_COMPLETE : fre_pkg::ST_STORED;
				len_out_q <= new_len;
				cnt_out_q <= new_cnt;
			end else begin
				status_q  <= head.kind;
				len_out_q <= length_q;
				cnt_out_q <= seen_count_q;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_payload_type = ptype_q;
	assign file_length      = 13'(len_out_q);
	assign frags_seen       = cnt_out_q;
	assign read_byte        = rd_ok_q ? rd_data_q : 8'd0;

endmodule

@@ dv/fre_tb_pkg.sv @@
// scoreboard and transaction types for the fragment reassembly engine testbench
package fre_tb_pkg;

	localparam int CHUNK_BYTES = 32;
	localparam int BUF_BYTES   = 4096;
	localparam int MAX_FRAGS   = 129;

	typedef struct {
		logic        mode;
		logic [31:0] tag;
		logic [7:0]  ptype;
		logic [7:0]  index;
		logic [7:0]  total;
		logic        enc;
		logic [4:0]  pos;
		logic [7:0]  data;
		logic        bvalid;
		logic        last;
		logic [11:0] raddr;
	} beat_t;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  ptype;
		logic [12:0] length;
		logic [7:0]  count;
		logic [7:0]  rbyte;
	} outcome_t;

	class reassembly_scoreboard;
		logic [7:0]  type_code [3];
		logic [7:0]  buffer_mem [BUF_BYTES];
		bit          written [BUF_BYTES];
		int          written_addrs [$];
		bit          seen [MAX_FRAGS];
		logic [7:0]  seen_count;
		logic [7:0]  expected_total;
		logic [31:0] current_tag;
		logic [12:0] assembled_len;
		outcome_t    expected_results [$];
		int          status_hits [6];
		int          errors;

		function new();
			type_code = '{8'd0, 8'd1, 8'd2};
			clear_assembly(32'd0, 8'd0);
			errors = 0;
		endfunction

		function void clear_assembly(logic [31:0] tag, logic [7:0] total);
			current_tag = tag;
			expected_total = total;
			seen_count = 8'd0;
			assembled_len = 13'd0;
			seen = '{default: 1'b0};
		endfunction

		function void note_beat(beat_t b);
			outcome_t r;
			int addr;
			r.status = fre_pkg::ST_STORED;
			r.ptype = b.ptype;
			r.rbyte = 8'd0;
			if (b.mode) begin
				r.status = fre_pkg::ST_READ;
				r.ptype = 8'd0;
				r.rbyte = buffer_mem[b.raddr];
			end else if (!b.enc) begin
				r.status = fre_pkg::ST_UNENC;
			end else if (b.ptype != type_code[0] && b.ptype != type_code[1] &&
					b.ptype != type_code[2]) begin
				r.status = fre_pkg::ST_BADTYPE;
			end else if (!b.bvalid && b.total <= 1) begin
				r.status = fre_pkg::ST_RUN;
			end else begin
				if (b.tag != current_tag || b.total != expected_total)
					clear_assembly(b.tag, b.total);
				addr = b.index * CHUNK_BYTES + b.pos;
				if (b.bvalid && b.index < MAX_FRAGS && addr < BUF_BYTES) begin
					buffer_mem[addr] = b.data;
					if (!written[addr]) begin
						written[addr] = 1'b1;
						written_addrs.push_back(addr);
					end
					if (addr + 1 > assembled_len)
						assembled_len = 13'(addr + 1);
				end
				if (b.last) begin
					if (b.index < MAX_FRAGS && !seen[b.index]) begin
						seen[b.index] = 1'b1;
						seen_count++;
					end
					if (seen_count >= expected_total)
						r.status = fre_pkg::ST_COMPLETE;
				end
			end
			r.length = assembled_len;
			r.count = seen_count;
			if (r.status == fre_pkg::ST_COMPLETE)
				clear_assembly(32'd0, 8'd0);
			status_hits[r.status]++;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [12:0] want, logic [12:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (expected_results.size() == 0) begin
				$error("status: expected none, got %0d", got.status);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", 13'(want.status), 13'(got.status));
			compare_field("out_payload_type", 13'(want.ptype), 13'(got.ptype));
			compare_field("file_length", want.length, got.length);
			compare_field("frags_seen", 13'(want.count), 13'(got.count));
			compare_field("read_byte", 13'(want.rbyte), 13'(got.rbyte));
		endfunction
	endclass

endpackage

@@ dv/tb_top.sv @@
// testbench top for the fragment reassembly engine with stimulus, stalls and checking
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 8;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [fre_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          mode;
	logic [31:0]                   name_tag;
	logic [7:0]                    payload_type;
	logic [7:0]                    frag_index;
	logic [7:0]                    frag_total;
	logic                          encrypted;
	logic [4:0]                    byte_pos;
	logic [7:0]                    data_byte;
	logic                          byte_valid;
	logic                          last_beat;
	logic [11:0]                   read_address;
	logic                          out_valid;
	logic                          out_ready;
	logic [2:0]                    status;
	logic [7:0]                    out_payload_type;
	logic [12:0]                   file_length;
	logic [7:0]                    frags_seen;
	logic [7:0]                    read_byte;

	fre_tb_pkg::reassembly_scoreboard sb;
	fre_tb_pkg::outcome_t             observed;
	int                               tx_idle_pct;
	int                               rx_idle_pct;
	bit                               rx_hold_req;
	int                               beats_sent;
	int                               idle_cycles;

	fragment_reassembly_engine_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.name_tag        (name_tag),
		.payload_type    (payload_type),
		.frag_index      (frag_index),
		.frag_total      (frag_total),
		.encrypted       (encrypted),
		.byte_pos        (byte_pos),
		.data_byte       (data_byte),
		.byte_valid      (byte_valid),
		.last_beat       (last_beat),
		.read_address    (read_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.out_payload_type(out_payload_type),
		.file_length     (file_length),
		.frags_seen      (frags_seen),
		.read_byte       (read_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed.status = status;
			observed.ptype = out_payload_type;
			observed.length = file_length;
			observed.count = frags_seen;
			observed.rbyte = read_byte;
			sb.check_result(observed);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic fre_tb_pkg::beat_t rand_beat();
		fre_tb_pkg::beat_t b;
		b.mode = 1'b0;
		b.tag = $urandom();
		b.ptype = 8'($urandom_range(255));
		b.index = 8'($urandom_range(255));
		b.total = 8'($urandom_range(255));
		b.enc = 1'($urandom_range(1));
		b.pos = 5'($urandom_range(31));
		b.data = 8'($urandom_range(255));
		b.bvalid = 1'($urandom_range(1));
		b.last = 1'($urandom_range(1));
		b.raddr = 12'($urandom_range(4095));
		return b;
	endfunction

	function automatic fre_tb_pkg::beat_t fragment_beat(logic md, logic [31:0] tag,
			logic [7:0] ptype, logic [7:0] index, logic [7:0] total, logic enc,
			logic [4:0] pos, logic [7:0] data, logic bvalid, logic last, logic [11:0] raddr);
		fre_tb_pkg::beat_t b;
		b.mode = md;
		b.tag = tag;
		b.ptype = ptype;
		b.index = index;
		b.total = total;
		b.enc = enc;
		b.pos = pos;
		b.data = data;
		b.bvalid = bvalid;
		b.last = last;
		b.raddr = raddr;
		return b;
	endfunction

	task automatic send(input fre_tb_pkg::beat_t b);
		in_valid <= 1'b1;
		mode <= b.mode;
		name_tag <= b.tag;
		payload_type <= b.ptype;
		frag_index <= b.index;
		frag_total <= b.total;
		encrypted <= b.enc;
		byte_pos <= b.pos;
		data_byte <= b.data;
		byte_valid <= b.bvalid;
		last_beat <= b.last;
		read_address <= b.raddr;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b);
		beats_sent++;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_results.size() != 0);
	endtask

	task automatic set_types(input logic [7:0] sub_code, ir_code, script_code);
		cfg_wr_en <= 1'b1;
		cfg_index <= fre_pkg::CFG_TYPE_SUB;
		cfg_data <= sub_code;
		@(posedge clk);
		cfg_index <= fre_pkg::CFG_TYPE_IR;
		cfg_data <= ir_code;
		@(posedge clk);
		cfg_index <= fre_pkg::CFG_TYPE_SCRIPT;
		cfg_data <= script_code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.type_code = '{sub_code, ir_code, script_code};
	endtask

	// reads, drops, run requests and stray beats
	task automatic send_noise();
		fre_tb_pkg::beat_t b;
		int pick;
		b = rand_beat();
		pick = $urandom_range(99);
		if (pick < 35 && sb.written_addrs.size() > 0) begin
			b.mode = 1'b1;
			b.raddr = 12'(sb.written_addrs[$urandom_range(sb.written_addrs.size() - 1)]);
		end else if (pick < 55) begin
			b.enc = 1'b0;
		end else if (pick < 75) begin
			b.enc = 1'b1;
			while (b.ptype == sb.type_code[0] || b.ptype == sb.type_code[1] ||
					b.ptype == sb.type_code[2])
				b.ptype = 8'($urandom_range(255));
		end else if (pick < 90) begin
			b.enc = 1'b1;
			b.ptype = sb.type_code[$urandom_range(2)];
			b.bvalid = 1'b0;
			b.total = 8'($urandom_range(1));
		end
		send(b);
	endtask

	task automatic send_file(input logic [31:0] tag, input logic [7:0] total);
		int order [$];
		int n, i, j, tmp, k, m, nbeats;
		bit empty;
		fre_tb_pkg::beat_t b;
		n = (total == 0) ? 1 : total;
		for (i = 0; i < n; i++)
			order.push_back(i);
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if ($urandom_range(9) == 0)
			order.push_back(order[0]);
		if ($urandom_range(9) == 0 && order.size() > 1)
			order.delete(order.size() - 1);
		for (k = 0; k < order.size(); k++) begin
			empty = (total > 1) && ($urandom_range(5) == 0);
			if (empty)
				nbeats = 1;
			else if ($urandom_range(7) == 0)
				nbeats = $urandom_range(32, 4);
			else
				nbeats = $urandom_range(3, 1);
			for (m = 0; m < nbeats; m++) begin
				if ($urandom_range(15) == 0)
					send_noise();
				b = rand_beat();
				b.enc = 1'b1;
				b.tag = tag;
				b.total = total;
				b.ptype = sb.type_code[$urandom_range(2)];
				b.index = 8'(order[k]);
				b.bvalid = !empty;
				b.last = (m == nbeats - 1);
				send(b);
			end
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int beats);
		int target, r;
		logic [31:0] tag;
		logic [7:0] total;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		target = beats_sent + beats;
		tag = $urandom();
		while (beats_sent < target) begin
			if ($urandom_range(9) == 0) begin
				send_noise();
			end else begin
				if ($urandom_range(9) < 7)
					tag = $urandom();
				r = $urandom_range(99);
				if (r < 5)
					total = 8'd0;
				else if (r < 75)
					total = 8'($urandom_range(4, 1));
				else if (r < 95)
					total = 8'($urandom_range(12, 5));
				else
					total = 8'($urandom_range(40, 13));
				send_file(tag, total);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = fre_pkg::CFG_TYPE_SUB;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		mode = 1'b0;
		name_tag = 32'd0;
		payload_type = 8'd0;
		frag_index = 8'd0;
		frag_total = 8'd0;
		encrypted = 1'b0;
		byte_pos = 5'd0;
		data_byte = 8'd0;
		byte_valid = 1'b0;
		last_beat = 1'b0;
		read_address = 12'd0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b0;
		beats_sent = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats with the reset type codes
		send(fragment_beat('0, 32'h0000_0000, 8'hff, 8'h00, 8'h00,
			'0, 5'd0, 8'h00, '1, '1, 12'h000));
		send(fragment_beat('0, 32'h1234_5678, 8'h80, 8'hff, 8'hff,
			'1, 5'd31, 8'hff, '1, '1, 12'hfff));
		send(fragment_beat('0, 32'hdead_beef, 8'h02, 8'h00, 8'h00,
			'1, 5'd0, 8'h00, '0, '1, 12'h000));
		send(fragment_beat('0, 32'hdead_beef, 8'h01, 8'h03, 8'h01,
			'1, 5'd7, 8'h5a, '0, '0, 12'h000));
		// zero total: completes at once, writes the top buffer byte
		send(fragment_beat('0, 32'hffff_ffff, 8'h00, 8'd127, 8'h00,
			'1, 5'd31, 8'hff, '1, '1, 12'h000));
		send(fragment_beat('1, 32'hffff_ffff, 8'hff, 8'hff, 8'hff,
			'1, 5'd31, 8'hff, '1, '1, 12'hfff));
		send(fragment_beat('0, 32'ha5a5_a5a5, 8'h01, 8'd0, 8'd2,
			'1, 5'd0, 8'h00, '1, '0, 12'h000));
		send(fragment_beat('0, 32'ha5a5_a5a5, 8'h01, 8'd0, 8'd2,
			'1, 5'd5, 8'h3c, '1, '1, 12'h000));
		// empty fragment of a multi-fragment file
		send(fragment_beat('0, 32'ha5a5_a5a5, 8'h01, 8'd1, 8'd2,
			'1, 5'd0, 8'h00, '0, '1, 12'h000));
		send(fragment_beat('1, 32'h0000_0000, 8'h00, 8'h00, 8'h00,
			'0, 5'd0, 8'h00, '0, '0, 12'h000));
		send(fragment_beat('1, 32'h0000_0000, 8'h00, 8'h00, 8'h00,
			'0, 5'd0, 8'h00, '0, '0, 12'h005));
		// indices past the buffer and past the fragment limit
		send(fragment_beat('0, 32'h5a5a_5a5a, 8'h02, 8'd128, 8'd255,
			'1, 5'd31, 8'haa, '1, '1, 12'h000));
		send(fragment_beat('0, 32'h5a5a_5a5a, 8'h02, 8'd255, 8'd255,
			'1, 5'd0, 8'h11, '1, '1, 12'h000));
		// new total restarts, then a repeated index
		send(fragment_beat('0, 32'h5a5a_5a5a, 8'h02, 8'd2, 8'd3,
			'1, 5'd2, 8'h22, '1, '1, 12'h000));
		send(fragment_beat('0, 32'h5a5a_5a5a, 8'h02, 8'd2, 8'd3,
			'1, 5'd3, 8'h33, '1, '1, 12'h000));
		// tag change mid assembly
		send(fragment_beat('0, 32'h0000_0001, 8'h00, 8'd0, 8'd3,
			'1, 5'd1, 8'h44, '1, '0, 12'h000));
		send(fragment_beat('0, 32'h0000_0001, 8'h00, 8'd0, 8'd3,
			'1, 5'd0, 8'h55, '1, '1, 12'h000));
		send(fragment_beat('0, 32'h0000_0001, 8'h01, 8'd1, 8'd3,
			'1, 5'd31, 8'h66, '1, '1, 12'h000));
		send(fragment_beat('0, 32'h0000_0001, 8'h02, 8'd2, 8'd3,
			'1, 5'd31, 8'h77, '1, '1, 12'h000));
		send(fragment_beat('1, 32'h0000_0001, 8'h02, 8'd2, 8'd3,
			'1, 5'd31, 8'h77, '1, '1, 12'h05f));
		send(fragment_beat('0, 32'hffff_ffff, 8'hff, 8'hff, 8'hff,
			'0, 5'd31, 8'hff, '1, '1, 12'hfff));
		wait_for_results();

		set_types(8'hff, 8'h00, 8'h7e);
		run_phase(27, 66, 440);
		wait_for_results();

		set_types(8'h10, 8'h10, 8'h10);
		run_phase(66, 27, 440);
		wait_for_results();

		set_types(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b1;
		send_file($urandom(), 8'd129);
		run_phase(0, 0, 160);
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions over four type-code settings, stalls on both sides",
			beats_sent);
		$display("%0d files completed, %0d stored, %0d reads, %0d drops, %0d run requests",
			sb.status_hits[fre_pkg::ST_COMPLETE], sb.status_hits[fre_pkg::ST_STORED],
			sb.status_hits[fre_pkg::ST_READ],
			sb.status_hits[fre_pkg::ST_UNENC] + sb.status_hits[fre_pkg::ST_BADTYPE],
			sb.status_hits[fre_pkg::ST_RUN]);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
